// ===== hdl/rv32_exu_pkg.sv =====
package rv32_exu_pkg;

  // major opcodes
  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcJal    = 7'h6f;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcFence  = 7'h0f;
  localparam logic [6:0] OpcSystem = 7'h73;
  localparam logic [6:0] OpcAmo    = 7'h2f;

  localparam logic [4:0] ShamtMask = 5'h1f;

  // memory op and trap codes
  localparam logic [1:0] MemNone  = 2'd0;
  localparam logic [1:0] MemLoad  = 2'd1;
  localparam logic [1:0] MemStore = 2'd2;
  localparam logic [1:0] TrapNone    = 2'd0;
  localparam logic [1:0] TrapIllegal = 2'd1;
  localparam logic [1:0] TrapSystem  = 2'd2;

  // funct7 codes
  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7MulDiv = 7'h01;
  localparam logic [6:0] F7Alt  = 7'h20;

  // one divider bit per pipeline stage
  localparam int DivSteps = 32;

  typedef struct packed {
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [1:0]  mem_size;
    logic        mem_unsigned;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
    logic [1:0]  trap_kind;
  } result_t;

  typedef struct packed {
    logic        vld;
    result_t     res;
    logic        is_mul;
    logic        is_div;
    logic [2:0]  f3;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic        neg_q;
    logic        neg_r;
    logic        bzero;
  } pipe_t;

  // one restoring division step: shift in the next dividend bit
  function automatic pipe_t div_step(input pipe_t p);
    pipe_t       q;
    logic [32:0] t;
    q = p;
    t = {p.rem, p.quo[31]};
    if (t >= {1'b0, p.dvs}) begin
      q.rem = 32'(t - {1'b0, p.dvs});
      q.quo = {p.quo[30:0], 1'b1};
    end else begin
      q.rem = t[31:0];
      q.quo = {p.quo[30:0], 1'b0};
    end
    return q;
  endfunction

endpackage

// ===== hdl/rv32im_execute_unit.sv =====
// RV32IM execute unit. Each word carries one instruction with its pc and both
// source register values, and yields exactly one result word in program order.
// The unit is a 34-stage pipeline: decode and all the ALU, branch,
// jump and address work in the first stage, then 32 stages of which the first
// also forms the 32x32 product and each retires one quotient bit of the
// restoring divider, then a stage that applies sign and divide-by-zero fixes.
// It accepts one word per cycle unless stalled; a word passes st_r[0] to st_r[32]
// and out_r. The whole pipeline holds while a result waits on out_ready, so
// in_ready is low exactly when out_valid is high and out_ready is low. Loads give
// the address only (rd_write 0); system, CSR and atomic opcodes set trap_kind 2,
// illegal encodings trap_kind 1, both with next_pc = pc+4 and all else zero.
module rv32im_execute_unit import rv32_exu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_pc_value,
  input  logic [31:0] in_rs1_value,
  input  logic [31:0] in_rs2_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_rd_index,
  output logic        out_rd_write,
  output logic [31:0] out_rd_value,
  output logic [31:0] out_next_pc,
  output logic [1:0]  out_mem_op,
  output logic [1:0]  out_mem_size,
  output logic        out_mem_unsigned,
  output logic [31:0] out_mem_addr,
  output logic [31:0] out_store_data,
  output logic [1:0]  out_trap_kind
);

  logic    adv;
  pipe_t   dec_nxt;
  pipe_t   st_r   [0:DivSteps];
  pipe_t   st_nxt [1:DivSteps];
  result_t out_r, out_nxt;
  logic    out_vld_r;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // decode and first-stage execute
  always_comb begin
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, pc4;
    logic [6:0]  opc, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        taken, na, nb;
    a     = in_rs1_value;
    b     = in_rs2_value;
    opc   = in_instruction[6:0];
    rd    = in_instruction[11:7];
    f3    = in_instruction[14:12];
    f7    = in_instruction[31:25];
    imm_i = {{20{in_instruction[31]}}, in_instruction[31:20]};
    imm_s = {{20{in_instruction[31]}}, in_instruction[31:25], in_instruction[11:7]};
    imm_b = {{19{in_instruction[31]}}, in_instruction[31], in_instruction[7],
             in_instruction[30:25], in_instruction[11:8], 1'b0};
    imm_j = {{11{in_instruction[31]}}, in_instruction[31], in_instruction[19:12],
             in_instruction[20], in_instruction[30:21], 1'b0};
    imm_u = {in_instruction[31:12], 12'h000};
    pc4   = in_pc_value + 32'd4;
    taken = 1'b0;
    na    = 1'b0;
    nb    = 1'b0;

    dec_nxt             = '0;
    dec_nxt.vld         = in_valid;
    dec_nxt.f3          = f3;
    dec_nxt.opa         = a;
    dec_nxt.opb         = b;
    dec_nxt.res.next_pc = pc4;

    unique case (opc)
      OpcLoad: begin
        if (f3 == 3'd3 || f3 >= 3'd6) begin
          dec_nxt.res.trap_kind = TrapIllegal;
        end else begin
          dec_nxt.res.rd_index     = rd;
          dec_nxt.res.mem_op       = MemLoad;
          dec_nxt.res.mem_size     = f3[1:0];
          dec_nxt.res.mem_unsigned = f3[2];
          dec_nxt.res.mem_addr     = a + imm_i;
        end
      end
      OpcStore: begin
        if (f3 > 3'd2) begin
          dec_nxt.res.trap_kind = TrapIllegal;
        end else begin
          dec_nxt.res.mem_op     = MemStore;
          dec_nxt.res.mem_size   = f3[1:0];
          dec_nxt.res.mem_addr   = a + imm_s;
          dec_nxt.res.store_data = b;
        end
      end
      OpcOp: begin
        if (f7 == F7MulDiv) begin
          dec_nxt.is_mul = !f3[2];
          dec_nxt.is_div = f3[2];
          na = !f3[0] && a[31];
          nb = !f3[0] && b[31];
          dec_nxt.quo   = na ? 32'(0 - a) : a;
          dec_nxt.dvs   = nb ? 32'(0 - b) : b;
          dec_nxt.neg_q = na ^ nb;
          dec_nxt.neg_r = na;
          dec_nxt.bzero = (b == 32'd0);
          dec_nxt.res.rd_index = rd;
          dec_nxt.res.rd_write = 1'b1;
        end else if (f7 == F7Base || (f7 == F7Alt && (f3 == 3'd0 || f3 == 3'd5))) begin
          dec_nxt.res.rd_index = rd;
          dec_nxt.res.rd_write = 1'b1;
          case (f3)
            3'd0: dec_nxt.res.rd_value = f7[5] ? a - b : a + b;
            3'd1: dec_nxt.res.rd_value = a << (b[4:0] & ShamtMask);
            3'd2: dec_nxt.res.rd_value = {31'd0, $signed(a) < $signed(b)};
            3'd3: dec_nxt.res.rd_value = {31'd0, a < b};
            3'd4: dec_nxt.res.rd_value = a ^ b;
            3'd5: dec_nxt.res.rd_value = f7[5] ? 32'($signed(a) >>> b[4:0])
                                               : a >> b[4:0];
            3'd6: dec_nxt.res.rd_value = a | b;
            default: dec_nxt.res.rd_value = a & b;
          endcase
        end else begin
          dec_nxt.res.trap_kind = TrapIllegal;
        end
      end
      OpcOpImm: begin
        case (f3)
          3'd0: dec_nxt.res.rd_value = a + imm_i;
          3'd1: begin
            if (f7 != F7Base) dec_nxt.res.trap_kind = TrapIllegal;
            else dec_nxt.res.rd_value = a << imm_i[4:0];
          end
          3'd2: dec_nxt.res.rd_value = {31'd0, $signed(a) < $signed(imm_i)};
          3'd3: dec_nxt.res.rd_value = {31'd0, a < imm_i};
          3'd4: dec_nxt.res.rd_value = a ^ imm_i;
          3'd5: begin
            if (f7 == F7Base) dec_nxt.res.rd_value = a >> imm_i[4:0];
            else if (f7 == F7Alt) dec_nxt.res.rd_value = 32'($signed(a) >>> imm_i[4:0]);
            else dec_nxt.res.trap_kind = TrapIllegal;
          end
          3'd6: dec_nxt.res.rd_value = a | imm_i;
          default: dec_nxt.res.rd_value = a & imm_i;
        endcase
        dec_nxt.res.rd_index = rd;
        dec_nxt.res.rd_write = 1'b1;
      end
      OpcLui: begin
        dec_nxt.res.rd_index = rd;
        dec_nxt.res.rd_write = 1'b1;
        dec_nxt.res.rd_value = imm_u;
      end
      OpcAuipc: begin
        dec_nxt.res.rd_index = rd;
        dec_nxt.res.rd_write = 1'b1;
        dec_nxt.res.rd_value = in_pc_value + imm_u;
      end
      OpcJal: begin
        dec_nxt.res.rd_index = rd;
        dec_nxt.res.rd_write = 1'b1;
        dec_nxt.res.rd_value = pc4;
        dec_nxt.res.next_pc  = in_pc_value + imm_j;
      end
      OpcJalr: begin
        if (f3 != 3'd0) begin
          dec_nxt.res.trap_kind = TrapIllegal;
        end else begin
          dec_nxt.res.rd_index = rd;
          dec_nxt.res.rd_write = 1'b1;
          dec_nxt.res.rd_value = pc4;
          dec_nxt.res.next_pc  = (a + imm_i) & ~32'd1;
        end
      end
      OpcBranch: begin
        case (f3)
          3'd0: taken = (a == b);
          3'd1: taken = (a != b);
          3'd4: taken = $signed(a) < $signed(b);
          3'd5: taken = !($signed(a) < $signed(b));
          3'd6: taken = a < b;
          3'd7: taken = a >= b;
          default: dec_nxt.res.trap_kind = TrapIllegal;
        endcase
        if (taken) dec_nxt.res.next_pc = in_pc_value + imm_b;
      end
      OpcFence: begin
        if (f3 > 3'd1) dec_nxt.res.trap_kind = TrapIllegal;
      end
      OpcSystem, OpcAmo: dec_nxt.res.trap_kind = TrapSystem;
      default: dec_nxt.res.trap_kind = TrapIllegal;
    endcase

    // a trapped word carries only the sequential pc and its trap kind
    if (dec_nxt.res.trap_kind != TrapNone) begin
      dec_nxt.res         = '0;
      dec_nxt.res.next_pc = pc4;
      dec_nxt.res.trap_kind = (opc == OpcSystem || opc == OpcAmo) ? TrapSystem
                                                                   : TrapIllegal;
      dec_nxt.is_mul      = 1'b0;
      dec_nxt.is_div      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else if (adv) begin
      st_r[0] <= dec_nxt;
    end
  end

  // multiply (first stage) and divider bit stages
  for (genvar k = 1; k <= DivSteps; k++) begin : g_stage
    always_comb begin
      st_nxt[k] = st_r[k-1];
      if (st_r[k-1].is_div) begin
        st_nxt[k] = div_step(st_r[k-1]);
      end else if (k == 1 && st_r[k-1].is_mul) begin
        {st_nxt[k].rem, st_nxt[k].quo} = st_r[k-1].opa * st_r[k-1].opb;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (adv) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // sign fixes, high-word corrections and divide-by-zero results
  always_comb begin
    pipe_t       p;
    logic [31:0] ca, cb;
    p  = st_r[DivSteps];
    ca = p.opa[31] ? p.opb : 32'd0;
    cb = p.opb[31] ? p.opa : 32'd0;
    out_nxt = p.res;
    if (p.is_mul || p.is_div) begin
      case (p.f3)
        3'd0: out_nxt.rd_value = p.quo;
        3'd1: out_nxt.rd_value = p.rem - ca - cb;
        3'd2: out_nxt.rd_value = p.rem - ca;
        3'd3: out_nxt.rd_value = p.rem;
        3'd4: out_nxt.rd_value = p.bzero ? 32'hffff_ffff
                                         : (p.neg_q ? 32'(0 - p.quo) : p.quo);
        3'd5: out_nxt.rd_value = p.bzero ? 32'hffff_ffff : p.quo;
        3'd6: out_nxt.rd_value = p.bzero ? p.opa
                                         : (p.neg_r ? 32'(0 - p.rem) : p.rem);
        default: out_nxt.rd_value = p.bzero ? p.opa : p.rem;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= st_r[DivSteps].vld;
      out_r     <= out_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_rd_index     = out_r.rd_index;
  assign out_rd_write     = out_r.rd_write;
  assign out_rd_value     = out_r.rd_value;
  assign out_next_pc      = out_r.next_pc;
  assign out_mem_op       = out_r.mem_op;
  assign out_mem_size     = out_r.mem_size;
  assign out_mem_unsigned = out_r.mem_unsigned;
  assign out_mem_addr     = out_r.mem_addr;
  assign out_store_data   = out_r.store_data;
  assign out_trap_kind    = out_r.trap_kind;

  // a held result stalls the whole pipe
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // a trapped word neither writes back nor touches memory
  a_trap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trap_kind != TrapNone |-> !out_rd_write && out_mem_op == MemNone)
    else $error("trap with side effects");

  // memory words never write the register file here
  a_mem_nowb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_op != MemNone |-> !out_rd_write)
    else $error("memory op with writeback");

  // a stalled result holds its valid into the next cycle
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped during stall");

endmodule
